// File: hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared definitions for the segment summary table
// Operation and status codes, plus the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

  typedef logic [2:0] opcode_t;
  typedef logic [2:0] status_t;

  localparam opcode_t OP_START     = 3'd0;
  localparam opcode_t OP_REC_FILE  = 3'd1;
  localparam opcode_t OP_REC_INODE = 3'd2;
  localparam opcode_t OP_RD_FILE   = 3'd3;
  localparam opcode_t OP_RD_INODE  = 3'd4;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_DUP        = 3'd1;
  localparam status_t ST_FILE_FULL  = 3'd2;
  localparam status_t ST_LIST_FULL  = 3'd3;
  localparam status_t ST_INODE_FULL = 3'd4;
  localparam status_t ST_BAD_INDEX  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic rd;
    logic finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_done;
  } dp_status_t;

endpackage

// File: hdl/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl: sequencing state machine for the segment summary table
// Accepts one beat at a time, steps the datapath through its scan or read,
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sst_pkg::opcode_t    opcode,
  output logic                out_valid,
  input  logic                out_stall,
  input  sst_pkg::dp_status_t dp_status,
  output sst_pkg::ctl_cmd_t   cmd
);
  import sst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (opcode inside {OP_REC_FILE, OP_REC_INODE}) begin
            state_next = S_SCAN;
          end else if (opcode inside {OP_RD_FILE, OP_RD_INODE}) begin
            state_next = S_READ;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (dp_status.match || dp_status.scan_done) begin
          state_next = S_FIN;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: hdl/sst_dpath.sv
// ----------------------------------------------------------------------------
// sst_dpath: tables, counters and result register of the segment summary table
// Holds the file entry, block pair and inode block memories, runs the
// pipelined lookup scan and forms the result on the finish command.
// ----------------------------------------------------------------------------
module sst_dpath #(
  parameter int FILE_ENTRIES    = 16,
  parameter int PAIRS_PER_ENTRY = 32,
  parameter int INODE_SLOTS     = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sst_pkg::ctl_cmd_t   cmd,
  output sst_pkg::dp_status_t dp_status,
  input  sst_pkg::opcode_t    opcode,
  input  logic [31:0]         inode_number,
  input  logic signed [31:0]  logical_block,
  input  logic [31:0]         disk_block,
  input  logic [3:0]          entry_index,
  input  logic [4:0]          slot_index,
  output sst_pkg::status_t    status,
  output logic [3:0]          entry_used,
  output logic [4:0]          slot_used,
  output logic                new_entry,
  output logic [4:0]          file_entries,
  output logic [5:0]          inode_blocks,
  output logic [31:0]         read_inode,
  output logic [5:0]          read_count,
  output logic signed [31:0]  read_logical,
  output logic [31:0]         read_disk
);
  import sst_pkg::*;

  localparam int EIDX_W     = $clog2(FILE_ENTRIES > 1 ? FILE_ENTRIES : 2);
  localparam int IIDX_W     = $clog2(INODE_SLOTS > 1 ? INODE_SLOTS : 2);
  localparam int UE_W       = $clog2(FILE_ENTRIES + 1);
  localparam int UI_W       = $clog2(INODE_SLOTS + 1);
  localparam int CNT_W      = $clog2(PAIRS_PER_ENTRY + 1);
  localparam int PAIR_DEPTH = FILE_ENTRIES * PAIRS_PER_ENTRY;
  localparam int PA_W       = $clog2(PAIR_DEPTH > 1 ? PAIR_DEPTH : 2);
  localparam int MAX_SCAN   = FILE_ENTRIES > INODE_SLOTS ? FILE_ENTRIES : INODE_SLOTS;
  localparam int SCAN_W     = $clog2(MAX_SCAN + 1);

  localparam logic [UE_W-1:0]  FE_C  = UE_W'(FILE_ENTRIES);
  localparam logic [UI_W-1:0]  IS_C  = UI_W'(INODE_SLOTS);
  localparam logic [CNT_W-1:0] PPE_C = CNT_W'(PAIRS_PER_ENTRY);
  localparam logic [PA_W:0]    PPE_A = (PA_W + 1)'(PAIRS_PER_ENTRY);

  // Captured item.
  opcode_t            op;
  logic [31:0]        ino;
  logic signed [31:0] lbn;
  logic [31:0]        blk;
  logic [3:0]         eidx;
  logic [4:0]         sidx;

  // Memories and their registered read data.
  logic [31:0]        ent_inode_mem [FILE_ENTRIES];
  logic [CNT_W-1:0]   ent_count_mem [FILE_ENTRIES];
  logic signed [31:0] pair_lbn_mem  [PAIR_DEPTH];
  logic [31:0]        pair_disk_mem [PAIR_DEPTH];
  logic [31:0]        inode_mem     [INODE_SLOTS];

  logic [31:0]        ent_inode_q;
  logic [CNT_W-1:0]   ent_count_q;
  logic signed [31:0] pair_lbn_q;
  logic [31:0]        pair_disk_q;
  logic [31:0]        inode_q;

  // Counters and scan state.
  logic [UE_W-1:0]    used_entries;
  logic [UI_W-1:0]    used_inodes;
  logic [UE_W-1:0]    used_entries_next;
  logic [UI_W-1:0]    used_inodes_next;
  logic [SCAN_W-1:0]  ptr;
  logic [SCAN_W-1:0]  pend_idx;
  logic               pend;
  logic               found;
  logic [EIDX_W-1:0]  hit_idx;
  logic [CNT_W-1:0]   hit_cnt;

  logic               is_file;
  logic [SCAN_W-1:0]  limit;
  logic               issue;
  logic               match;

  logic               ent_ren;
  logic [EIDX_W-1:0]  ent_raddr;
  logic               ino_ren;
  logic [IIDX_W-1:0]  ino_raddr;
  logic               pair_ren;
  logic [PA_W:0]      pair_rsum;
  logic               sidx_ok;

  logic               ent_we;
  logic [EIDX_W-1:0]  ent_waddr;
  logic [CNT_W-1:0]   ent_wcnt;
  logic               pair_we;
  logic [EIDX_W-1:0]  pair_widx;
  logic [CNT_W-1:0]   pair_wslot;
  logic [PA_W:0]      pair_wsum;
  logic               ino_we;

  logic               rd_file_ok;
  logic               rd_inode_ok;

  status_t            res_status;
  logic [3:0]         res_entry;
  logic [4:0]         res_slot;
  logic               res_new;
  logic [31:0]        res_inode;
  logic [5:0]         res_count;
  logic signed [31:0] res_logical;
  logic [31:0]        res_disk;

  // Lookup scan: one read issued per cycle, compared in the next cycle.
  assign is_file = (op == OP_REC_FILE);
  assign limit   = is_file ? SCAN_W'(used_entries) : SCAN_W'(used_inodes);
  assign issue   = cmd.scan && (ptr < limit);
  assign match   = pend && (is_file ? (ent_inode_q == ino) : (inode_q == blk));

  assign dp_status.match     = match;
  assign dp_status.scan_done = !pend && !(ptr < limit);

  assign sidx_ok   = ({27'd0, sidx} < 32'(PAIRS_PER_ENTRY));
  assign ent_ren   = (issue && is_file) || (cmd.rd && op == OP_RD_FILE);
  assign ent_raddr = cmd.rd ? EIDX_W'(eidx) : EIDX_W'(ptr);
  assign ino_ren   = (issue && !is_file) || (cmd.rd && op == OP_RD_INODE);
  assign ino_raddr = cmd.rd ? IIDX_W'(eidx) : IIDX_W'(ptr);
  assign pair_ren  = cmd.rd && (op == OP_RD_FILE);
  assign pair_rsum = (PA_W + 1)'(EIDX_W'(eidx)) * PPE_A
                   + (PA_W + 1)'(sidx_ok ? sidx : 5'd0);
  assign pair_wsum = (PA_W + 1)'(pair_widx) * PPE_A + (PA_W + 1)'(pair_wslot);

  // Entry count never exceeds the pair limit, so the slot check covers it.
  assign rd_file_ok  = ({28'd0, eidx} < 32'(used_entries)) && ({27'd0, sidx} < 32'(ent_count_q));
  assign rd_inode_ok = ({28'd0, eidx} < 32'(used_inodes));

  always_comb begin
    used_entries_next = used_entries;
    used_inodes_next  = used_inodes;
    ent_we      = 1'b0;
    ent_waddr   = hit_idx;
    ent_wcnt    = CNT_W'(hit_cnt + 1'b1);
    pair_we     = 1'b0;
    pair_widx   = hit_idx;
    pair_wslot  = hit_cnt;
    ino_we      = 1'b0;
    res_status  = ST_OK;
    res_entry   = 4'd0;
    res_slot    = 5'd0;
    res_new     = 1'b0;
    res_inode   = 32'd0;
    res_count   = 6'd0;
    res_logical = 32'sd0;
    res_disk    = 32'd0;
    case (op)
      OP_START: begin
        used_entries_next = '0;
        used_inodes_next  = '0;
      end
      OP_REC_FILE: begin
        if (found) begin
          res_entry = 4'(hit_idx);
          if (hit_cnt >= PPE_C) begin
            res_status = ST_LIST_FULL;
          end else begin
            ent_we   = 1'b1;
            pair_we  = 1'b1;
            res_slot = 5'(hit_cnt);
          end
        end else if (used_entries >= FE_C) begin
          res_status = ST_FILE_FULL;
        end else begin
          ent_we            = 1'b1;
          ent_waddr         = EIDX_W'(used_entries);
          ent_wcnt          = CNT_W'(1);
          pair_we           = 1'b1;
          pair_widx         = EIDX_W'(used_entries);
          pair_wslot        = '0;
          used_entries_next = UE_W'(used_entries + 1'b1);
          res_entry         = 4'(used_entries);
          res_new           = 1'b1;
        end
      end
      OP_REC_INODE: begin
        if (found) begin
          res_status = ST_DUP;
        end else if (used_inodes >= IS_C) begin
          res_status = ST_INODE_FULL;
        end else begin
          ino_we           = 1'b1;
          used_inodes_next = UI_W'(used_inodes + 1'b1);
        end
      end
      OP_RD_FILE: begin
        if (rd_file_ok) begin
          res_inode   = ent_inode_q;
          res_count   = 6'(ent_count_q);
          res_logical = pair_lbn_q;
          res_disk    = pair_disk_q;
        end else begin
          res_status = ST_BAD_INDEX;
        end
      end
      OP_RD_INODE: begin
        if (rd_inode_ok) begin
          res_disk = inode_q;
        end else begin
          res_status = ST_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: counters, scan pointer and hit flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_entries <= '0;
      used_inodes  <= '0;
      ptr          <= '0;
      pend         <= 1'b0;
      found        <= 1'b0;
    end else if (cmd.capture) begin
      ptr   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      ptr  <= SCAN_W'(ptr + SCAN_W'(issue));
      pend <= issue;
      if (match) begin
        found <= 1'b1;
      end
    end else if (cmd.finish) begin
      used_entries <= used_entries_next;
      used_inodes  <= used_inodes_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= opcode;
      ino  <= inode_number;
      lbn  <= logical_block;
      blk  <= disk_block;
      eidx <= entry_index;
      sidx <= slot_index;
    end
    if (cmd.scan) begin
      pend_idx <= ptr;
      if (match) begin
        hit_idx <= EIDX_W'(pend_idx);
        hit_cnt <= ent_count_q;
      end
    end
    if (cmd.finish) begin
      status       <= res_status;
      entry_used   <= res_entry;
      slot_used    <= res_slot;
      new_entry    <= res_new;
      file_entries <= 5'(used_entries_next);
      inode_blocks <= 6'(used_inodes_next);
      read_inode   <= res_inode;
      read_count   <= res_count;
      read_logical <= res_logical;
      read_disk    <= res_disk;
    end
  end

  // File entry memories.
  always_ff @(posedge clk) begin
    if (cmd.finish && ent_we) begin
      ent_inode_mem[ent_waddr] <= ino;
      ent_count_mem[ent_waddr] <= ent_wcnt;
    end
    if (ent_ren) begin
      ent_inode_q <= ent_inode_mem[ent_raddr];
      ent_count_q <= ent_count_mem[ent_raddr];
    end
  end

  // Block pair memories.
  always_ff @(posedge clk) begin
    if (cmd.finish && pair_we) begin
      pair_lbn_mem[pair_wsum[PA_W-1:0]]  <= lbn;
      pair_disk_mem[pair_wsum[PA_W-1:0]] <= blk;
    end
    if (pair_ren) begin
      pair_lbn_q  <= pair_lbn_mem[pair_rsum[PA_W-1:0]];
      pair_disk_q <= pair_disk_mem[pair_rsum[PA_W-1:0]];
    end
  end

  // Inode block memory.
  always_ff @(posedge clk) begin
    if (cmd.finish && ino_we) begin
      inode_mem[IIDX_W'(used_inodes)] <= blk;
    end
    if (ino_ren) begin
      inode_q <= inode_mem[ino_raddr];
    end
  end

endmodule

// File: hdl/segment_summary_table.sv
// A record scans the entries in use in its table and stops at the first hit
// before it loads its result; a read first does its memory reads, and a start
// or unused opcode loads its result directly. Each result waits for a free output slot.
// One item at a time: the next beat is taken in the cycle after the
// result is loaded, even while that result still waits on out_stall.
// Reset clears both counts and the output valid; table memories are not cleared.
// ----------------------------------------------------------------------------
// segment_summary_table: segment summary builder for a log-structured store
// Records file block pairs under per-inode entries and inode block addresses,
// and reads either back by index.
// ----------------------------------------------------------------------------
module segment_summary_table #(
  parameter int FILE_ENTRIES    = 16,
  parameter int PAIRS_PER_ENTRY = 32,
  parameter int INODE_SLOTS     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sst_pkg::opcode_t   opcode,
  input  logic [31:0]        inode_number,
  input  logic signed [31:0] logical_block,
  input  logic [31:0]        disk_block,
  input  logic [3:0]         entry_index,
  input  logic [4:0]         slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output sst_pkg::status_t   status,
  output logic [3:0]         entry_used,
  output logic [4:0]         slot_used,
  output logic               new_entry,
  output logic [4:0]         file_entries,
  output logic [5:0]         inode_blocks,
  output logic [31:0]        read_inode,
  output logic [5:0]         read_count,
  output logic signed [31:0] read_logical,
  output logic [31:0]        read_disk
);
  import sst_pkg::*;

  // The controller only sequences; every table, counter and result register
  // lives in the datapath. Commands go one way and scan status the other.
  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  // The controller accepts a beat only in its idle state. It decodes the
  // opcode on the port at acceptance to pick the scan, read or direct path.
  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // The datapath scans the entries in use one per cycle with the compare in the
  // cycle after the memory read, stops at the first hit, and on the finish
  // command writes the tables and loads the output register together, so a
  // result is produced exactly once per accepted beat.
  sst_dpath #(
    .FILE_ENTRIES    (FILE_ENTRIES),
    .PAIRS_PER_ENTRY (PAIRS_PER_ENTRY),
    .INODE_SLOTS     (INODE_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .dp_status     (dp_status),
    .opcode        (opcode),
    .inode_number  (inode_number),
    .logical_block (logical_block),
    .disk_block    (disk_block),
    .entry_index   (entry_index),
    .slot_index    (slot_index),
    .status        (status),
    .entry_used    (entry_used),
    .slot_used     (slot_used),
    .new_entry     (new_entry),
    .file_entries  (file_entries),
    .inode_blocks  (inode_blocks),
    .read_inode    (read_inode),
    .read_count    (read_count),
    .read_logical  (read_logical),
    .read_disk     (read_disk)
  );

endmodule

// File: hdl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker: port-level assertions for the segment summary table
// Watches the handshakes and result fields over time, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sst_pkg::status_t   status,
  input logic               new_entry,
  input logic [4:0]         file_entries,
  input logic [31:0]        read_inode,
  input logic [5:0]         read_count,
  input logic signed [31:0] read_logical,
  input logic [31:0]        read_disk
);
  import sst_pkg::*;

  // No result is pending right after reset.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // The block works on one item at a time, so it stalls after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_disk)))
    else $error("stalled result changed");

  // A bad read index reports no stored data.
  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD_INDEX) |->
    (read_inode == 32'd0 && read_count == 6'd0 && read_logical == 32'sd0 &&
     read_disk == 32'd0))
    else $error("read fields not zero on bad index");

  // Opening an entry succeeds and leaves at least one entry in use.
  a_new_entry_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_entry) |-> (status == ST_OK && file_entries != 5'd0))
    else $error("new entry reported with failure status or empty table");

endmodule

bind segment_summary_table sst_checker u_sst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .new_entry    (new_entry),
  .file_entries (file_entries),
  .read_inode   (read_inode),
  .read_count   (read_count),
  .read_logical (read_logical),
  .read_disk    (read_disk)
);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the segment summary table
// A short table of directed requests covers the field extremes, every opcode,
// the ignored opcodes and the duplicate and bad-index outcomes. After it
// come randomly shaped segments: mixed traffic, a block list filled past its
// end, a file table and an inode table each filled up to or past their end,
// and plain noise. A cycle-accurate-free behavioral copy of the table
// predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import sst_pkg::*;

  localparam int FILES         = 16;
  localparam int PAIRS         = 32;
  localparam int ISLOTS        = 32;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 460;
  localparam int IDLE_PCT      = 23;
  localparam int QUIET_FROM    = 2000;
  localparam int QUIET_TO      = 3500;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 25;

  // One request as the block sees it on its input ports.
  typedef struct packed {
    opcode_t            op;
    logic [31:0]        ino;
    logic signed [31:0] lbn;
    logic [31:0]        pba;
    logic [3:0]         eidx;
    logic [4:0]         sidx;
  } request_t;

  // One result beat, in output port order.
  typedef struct packed {
    status_t            status;
    logic [3:0]         entry_used;
    logic [4:0]         slot_used;
    logic               new_entry;
    logic [4:0]         file_entries;
    logic [5:0]         inode_blocks;
    logic [31:0]        read_inode;
    logic [5:0]         read_count;
    logic signed [31:0] read_logical;
    logic [31:0]        read_disk;
  } summary_t;

  // A directed row: the request, and a hand-written result where one is given.
  typedef struct packed {
    request_t req;
    logic     typed;
    summary_t want;
  } table_row_t;

  // An entry of the send plan. A drain entry carries no request; the sender
  // holds off at it until every outstanding result has come back.
  typedef struct packed {
    request_t req;
    logic     drain;
    logic     typed;
    summary_t want;
  } planned_beat_t;

  localparam summary_t NO_WANT = '0;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  opcode_t            opcode = OP_START;
  logic [31:0]        inode_number = '0;
  logic signed [31:0] logical_block = '0;
  logic [31:0]        disk_block = '0;
  logic [3:0]         entry_index = '0;
  logic [4:0]         slot_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            status;
  logic [3:0]         entry_used;
  logic [4:0]         slot_used;
  logic               new_entry;
  logic [4:0]         file_entries;
  logic [5:0]         inode_blocks;
  logic [31:0]        read_inode;
  logic [5:0]         read_count;
  logic signed [31:0] read_logical;
  logic [31:0]        read_disk;

  segment_summary_table #(
    .FILE_ENTRIES   (FILES),
    .PAIRS_PER_ENTRY(PAIRS),
    .INODE_SLOTS    (ISLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .inode_number (inode_number),
    .logical_block(logical_block),
    .disk_block   (disk_block),
    .entry_index  (entry_index),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .entry_used   (entry_used),
    .slot_used    (slot_used),
    .new_entry    (new_entry),
    .file_entries (file_entries),
    .inode_blocks (inode_blocks),
    .read_inode   (read_inode),
    .read_count   (read_count),
    .read_logical (read_logical),
    .read_disk    (read_disk)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the summary table. The entry and pair stores are only ever
  // read below the matching counts, so their contents before a write never
  // matter.
  // --------------------------------------------------------------------------
  logic [31:0]        file_inode [FILES];
  logic [5:0]         file_pairs [FILES];
  logic signed [31:0] pair_lbn   [FILES][PAIRS];
  logic [31:0]        pair_pba   [FILES][PAIRS];
  logic [31:0]        iblock_list[ISLOTS];
  logic [4:0]         files_open = '0;
  logic [5:0]         iblocks_used = '0;

  // Bench bookkeeping.
  planned_beat_t plan[$];
  summary_t      pending_summaries[$];
  planned_beat_t on_bus;
  int            cycles = 0;
  int            errors = 0;
  int            sent = 0;
  int            checked = 0;
  int            pauses = 0;
  int            random_items = 0;
  int            idle_tail = 0;
  int            status_seen[8];
  logic          finished = 1'b0;

  // Applies one request to the shadow table and returns the result that the
  // block must give for it.
  function automatic summary_t apply_to_summary(request_t r);
    summary_t   s;
    logic [4:0] hit;
    logic       found;
    logic [5:0] n;
    s = '0;
    case (r.op)
      OP_START: begin
        files_open   = '0;
        iblocks_used = '0;
      end
      OP_REC_FILE: begin
        found = 1'b0;
        hit   = files_open;
        for (int i = 0; i < FILES; i++) begin
          if (!found && i < files_open && file_inode[i] == r.ino) begin
            found = 1'b1;
            hit   = 5'(i);
          end
        end
        if (found) begin
          // Known inode: append to its block list unless the list is full.
          s.entry_used = hit[3:0];
          n = file_pairs[hit];
          if (n >= PAIRS) begin
            s.status = ST_LIST_FULL;
          end else begin
            pair_lbn[hit][n[4:0]] = r.lbn;
            pair_pba[hit][n[4:0]] = r.pba;
            file_pairs[hit]       = n + 6'd1;
            s.slot_used           = n[4:0];
          end
        end else if (files_open >= FILES) begin
          s.status = ST_FILE_FULL;
        end else begin
          // New inode: open the next entry with this pair as its first.
          file_inode[files_open]  = r.ino;
          file_pairs[files_open]  = 6'd1;
          pair_lbn[files_open][0] = r.lbn;
          pair_pba[files_open][0] = r.pba;
          s.entry_used            = files_open[3:0];
          s.new_entry             = 1'b1;
          files_open              = files_open + 5'd1;
        end
      end
      OP_REC_INODE: begin
        found = 1'b0;
        for (int i = 0; i < ISLOTS; i++) begin
          if (i < iblocks_used && iblock_list[i] == r.pba) found = 1'b1;
        end
        // The duplicate check wins over the full check.
        if (found) begin
          s.status = ST_DUP;
        end else if (iblocks_used >= ISLOTS) begin
          s.status = ST_INODE_FULL;
        end else begin
          iblock_list[iblocks_used] = r.pba;
          iblocks_used              = iblocks_used + 6'd1;
        end
      end
      OP_RD_FILE: begin
        if (r.eidx < files_open && r.sidx < file_pairs[r.eidx]) begin
          s.read_inode   = file_inode[r.eidx];
          s.read_count   = file_pairs[r.eidx];
          s.read_logical = pair_lbn[r.eidx][r.sidx];
          s.read_disk    = pair_pba[r.eidx][r.sidx];
        end else begin
          s.status = ST_BAD_INDEX;
        end
      end
      OP_RD_INODE: begin
        if (r.eidx < iblocks_used) s.read_disk = iblock_list[r.eidx];
        else s.status = ST_BAD_INDEX;
      end
      default: begin
        // The unused opcodes change nothing and report the counts only.
      end
    endcase
    s.file_entries = files_open;
    s.inode_blocks = iblocks_used;
    return s;
  endfunction

  // Compares one result beat with the oldest outstanding prediction.
  task automatic check_summary(summary_t got);
    summary_t want;
    if (pending_summaries.size() == 0) begin
      $error("result beat with no request outstanding: status %0d", got.status);
      errors++;
    end else begin
      want = pending_summaries.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_used !== want.entry_used) begin
        $error("entry_used: expected %0d, got %0d", want.entry_used, got.entry_used);
        errors++;
      end
      if (got.slot_used !== want.slot_used) begin
        $error("slot_used: expected %0d, got %0d", want.slot_used, got.slot_used);
        errors++;
      end
      if (got.new_entry !== want.new_entry) begin
        $error("new_entry: expected %0d, got %0d", want.new_entry, got.new_entry);
        errors++;
      end
      if (got.file_entries !== want.file_entries) begin
        $error("file_entries: expected %0d, got %0d", want.file_entries, got.file_entries);
        errors++;
      end
      if (got.inode_blocks !== want.inode_blocks) begin
        $error("inode_blocks: expected %0d, got %0d", want.inode_blocks, got.inode_blocks);
        errors++;
      end
      if (got.read_inode !== want.read_inode) begin
        $error("read_inode: expected %h, got %h", want.read_inode, got.read_inode);
        errors++;
      end
      if (got.read_count !== want.read_count) begin
        $error("read_count: expected %0d, got %0d", want.read_count, got.read_count);
        errors++;
      end
      if (got.read_logical !== want.read_logical) begin
        $error("read_logical: expected %0d, got %0d", want.read_logical, got.read_logical);
        errors++;
      end
      if (got.read_disk !== want.read_disk) begin
        $error("read_disk: expected %h, got %h", want.read_disk, got.read_disk);
        errors++;
      end
    end
  endtask

  // A random word, with the corner values showing up about one time in five.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A request with the given opcode and every other field random.
  function automatic request_t any_req(opcode_t op);
    request_t r;
    r.op   = op;
    r.ino  = pick_word();
    r.lbn  = pick_word();
    r.pba  = pick_word();
    r.eidx = 4'($urandom_range(0, 15));
    r.sidx = 5'($urandom_range(0, 31));
    return r;
  endfunction

  // Appends a random-part request to the send plan and counts it toward the
  // random total.
  task automatic queue_req(request_t r);
    planned_beat_t b;
    b = '{req: r, drain: 1'b0, typed: 1'b0, want: NO_WANT};
    plan.push_back(b);
    random_items++;
  endtask

  // Appends a point at which the sender waits for all results to come back.
  task automatic queue_drain();
    planned_beat_t b;
    b       = '0;
    b.drain = 1'b1;
    plan.push_back(b);
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is raised once, at the start.
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Send plan. The whole stimulus is laid out at time zero; the driver below
  // walks it one beat at a time.
  // --------------------------------------------------------------------------
  initial begin
    table_row_t    tbl[DIRECTED_ROWS];
    planned_beat_t b;
    request_t      r;
    logic [31:0]   ino_pool[20];
    logic [31:0]   blk_pool[40];
    int            kind;
    int            len;
    int            n_ino;
    int            n_blk;
    int            pick;

    // Directed rows. Where the result is obvious it is written out; the
    // remaining rows are checked against the shadow table.
    // Start a segment on a fresh block, then read back from empty tables.
    tbl[0]  = '{'{OP_START, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[1]  = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[2]  = '{'{OP_RD_INODE, 32'h0, 32'sh0, 32'h0, 4'hF, 5'h1F}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    // All-ones inode opens entry zero, then takes a second pair.
    tbl[3]  = '{'{OP_REC_FILE, 32'hFFFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 4'hF, 5'h1F},
                1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b1, 5'd1, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[4]  = '{'{OP_REC_FILE, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_OK, 4'd0, 5'd1, 1'b0, 5'd1, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    // Inode zero is a real inode number and opens entry one.
    tbl[5]  = '{'{OP_REC_FILE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_OK, 4'd1, 5'd0, 1'b1, 5'd2, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    // Read both pairs of entry zero, then just past its count and its index.
    tbl[6]  = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h01}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd0, 32'hFFFF_FFFF, 6'd2,
                  32'sh7FFF_FFFF, 32'h0}};
    tbl[7]  = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd0, 32'hFFFF_FFFF, 6'd2,
                  32'sh8000_0000, 32'hFFFF_FFFF}};
    tbl[8]  = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h02}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd2, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[9]  = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h2, 5'h00}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd2, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    // Inode blocks: a new address, the same address again, then address zero.
    tbl[10] = '{'{OP_REC_INODE, 32'h0, 32'sh0, 32'hFFFF_FFFF, 4'h0, 5'h00}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd1, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[11] = '{'{OP_REC_INODE, 32'h0, 32'sh0, 32'hFFFF_FFFF, 4'h0, 5'h00}, 1'b1,
                '{ST_DUP, 4'd0, 5'd0, 1'b0, 5'd2, 6'd1, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[12] = '{'{OP_REC_INODE, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'h0, 4'hF, 5'h1F}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[13] = '{'{OP_RD_INODE, 32'h0, 32'sh0, 32'h0, 4'h1, 5'h00}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[14] = '{'{OP_RD_INODE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h1F}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'hFFFF_FFFF}};
    tbl[15] = '{'{OP_RD_INODE, 32'h0, 32'sh0, 32'h0, 4'h2, 5'h00}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'h0}};
    // The three unused opcodes only report the counts.
    tbl[16] = '{'{opcode_t'(5), 32'h1234_5678, 32'sh0, 32'hFFFF_FFFF, 4'h0, 5'h00}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[17] = '{'{opcode_t'(6), 32'h0, 32'sh8000_0000, 32'h0, 4'h5, 5'h0A}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[18] = '{'{opcode_t'(7), 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 4'hF, 5'h1F},
                1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd2, 6'd2, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[19] = '{'{OP_REC_FILE, 32'h0, 32'sh5, 32'hA5A5_A5A5, 4'h0, 5'h00}, 1'b0, NO_WANT};
    tbl[20] = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h1, 5'h01}, 1'b0, NO_WANT};
    // A new segment empties both tables; old contents are out of reach.
    tbl[21] = '{'{OP_START, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 4'hF, 5'h1F}, 1'b1,
                '{ST_OK, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[22] = '{'{OP_RD_FILE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[23] = '{'{OP_RD_INODE, 32'h0, 32'sh0, 32'h0, 4'h0, 5'h00}, 1'b1,
                '{ST_BAD_INDEX, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 32'h0, 6'd0, 32'sh0, 32'h0}};
    tbl[24] = '{'{OP_REC_FILE, 32'h1234_5678, 32'sh0, 32'h5A5A_5A5A, 4'h0, 5'h00}, 1'b0,
                NO_WANT};

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      b = '{req: tbl[k].req, drain: 1'b0, typed: tbl[k].typed, want: tbl[k].want};
      plan.push_back(b);
    end
    queue_drain();

    // Random part: one segment at a time, each opened by a start beat.
    while (random_items < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 9);
      n_ino = $urandom_range(3, 20);
      n_blk = $urandom_range(4, 40);
      for (int k = 0; k < 20; k++) ino_pool[k] = pick_word();
      for (int k = 0; k < 40; k++) blk_pool[k] = pick_word();
      if ($urandom_range(0, 5) == 0) queue_drain();
      queue_req(any_req(OP_START));
      case (kind)
        0, 1, 2, 3, 4: begin
          // Mixed traffic over a small set of inodes and block addresses, so
          // that hits, duplicates and now and then a full file table occur.
          len = $urandom_range(10, 45);
          for (int j = 0; j < len; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
              r     = any_req(OP_REC_FILE);
              r.ino = ino_pool[$urandom_range(0, n_ino - 1)];
            end else if (pick < 65) begin
              r     = any_req(OP_REC_INODE);
              r.pba = blk_pool[$urandom_range(0, n_blk - 1)];
            end else if (pick < 80) begin
              r = any_req(OP_RD_FILE);
              if (pick[0]) r.sidx = 5'($urandom_range(0, 3));
              if (pick[1]) r.eidx = 4'($urandom_range(0, n_ino > 16 ? 15 : n_ino - 1));
            end else if (pick < 92) begin
              r = any_req(OP_RD_INODE);
              if (pick[0]) r.eidx = 4'($urandom_range(0, 3));
            end else begin
              r = any_req(opcode_t'($urandom_range(0, 7)));
            end
            queue_req(r);
          end
        end
        5: begin
          // One inode takes more pairs than its block list holds.
          len = $urandom_range(33, 36);
          for (int j = 0; j < len; j++) begin
            r     = any_req(OP_REC_FILE);
            r.ino = ino_pool[0];
            queue_req(r);
            if ($urandom_range(0, 4) == 0) begin
              r      = any_req(OP_RD_FILE);
              r.eidx = 4'd0;
              queue_req(r);
            end
          end
          r      = any_req(OP_RD_FILE);
          r.eidx = 4'd0;
          r.sidx = 5'd31;
          queue_req(r);
        end
        6: begin
          // As many distinct inodes as there are file entries, or more.
          len = $urandom_range(16, 20);
          for (int j = 0; j < len; j++) begin
            r     = any_req(OP_REC_FILE);
            r.ino = ino_pool[j];
            queue_req(r);
          end
          for (int j = 0; j < 3; j++) begin
            r     = any_req(OP_REC_FILE);
            r.ino = ino_pool[$urandom_range(0, 15)];
            queue_req(r);
          end
          r      = any_req(OP_RD_FILE);
          r.eidx = 4'd15;
          r.sidx = 5'd0;
          queue_req(r);
        end
        7: begin
          // At least as many inode block addresses as there are slots, with repeats.
          len = $urandom_range(32, 36);
          for (int j = 0; j < len; j++) begin
            r     = any_req(OP_REC_INODE);
            r.pba = blk_pool[j];
            queue_req(r);
            if ($urandom_range(0, 4) == 0) begin
              r.pba = blk_pool[$urandom_range(0, j)];
              queue_req(r);
            end
          end
          r      = any_req(OP_RD_INODE);
          r.eidx = 4'd15;
          queue_req(r);
        end
        default: begin
          // Noise: any opcode, any fields.
          len = $urandom_range(8, 20);
          for (int j = 0; j < len; j++) queue_req(any_req(opcode_t'($urandom_range(0, 7))));
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Driver and monitor in one clocked process, so that the plan, the send
  // side and the result side never race within a time step. Port values are
  // sampled as they stood before the edge; new inputs go out as nonblocking
  // updates. Both sides idle at random except inside a quiet window.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    summary_t got;
    summary_t prediction;
    logic     quiet;
    logic     gap;
    cycles++;
    if (!rst) begin
      quiet = cycles >= QUIET_FROM && cycles < QUIET_TO;

      // Result side: a beat moves when valid is high and we are not stalling.
      if (out_valid && !out_stall) begin
        got = '{status, entry_used, slot_used, new_entry, file_entries, inode_blocks,
                read_inode, read_count, read_logical, read_disk};
        check_summary(got);
      end

      // Send side: predict the result of each beat the block takes.
      if (in_valid && !in_stall) begin
        prediction = apply_to_summary(on_bus.req);
        pending_summaries.push_back(on_bus.typed ? on_bus.want : prediction);
        sent++;
      end

      // A stalled beat is held as it is. Otherwise the bus is free for the
      // next beat, unless the plan asks us to wait for the results to drain.
      if (!in_valid || !in_stall) begin
        while (plan.size() > 0 && plan[0].drain && pending_summaries.size() == 0) begin
          void'(plan.pop_front());
          pauses++;
        end
        gap = !quiet && $urandom_range(0, 99) < IDLE_PCT;
        if (!gap && plan.size() > 0 && !plan[0].drain) begin
          on_bus = plan.pop_front();
          in_valid      <= 1'b1;
          opcode        <= on_bus.req.op;
          inode_number  <= on_bus.req.ino;
          logical_block <= on_bus.req.lbn;
          disk_block    <= on_bus.req.pba;
          entry_index   <= on_bus.req.eidx;
          slot_index    <= on_bus.req.sidx;
        end else begin
          in_valid <= 1'b0;
        end
      end

      out_stall <= !quiet && $urandom_range(0, 99) < IDLE_PCT;

      // Once everything is sent and answered, keep watching for a while so
      // that a stray extra result beat is still caught.
      if (plan.size() == 0 && !in_valid && pending_summaries.size() == 0) idle_tail++;
      else idle_tail = 0;
      if (idle_tail >= TAIL_CYCLES) finished = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // End of run: either the traffic finished cleanly or the cycle limit hit.
  // --------------------------------------------------------------------------
  initial begin
    while (!finished && cycles < CYCLE_LIMIT) @(negedge clk);
    if (!finished) begin
      $error("cycle limit reached with %0d results outstanding", pending_summaries.size());
      $display("DONE: errors detected");
    end else begin
      $display("Sent %0d requests and checked %0d results in %0d cycles, %0d drain pauses.",
               sent, checked, cycles, pauses);
      $display("Outcomes: dup %0d, file full %0d, list full %0d, inode full %0d, bad index %0d.",
               status_seen[ST_DUP], status_seen[ST_FILE_FULL], status_seen[ST_LIST_FULL],
               status_seen[ST_INODE_FULL], status_seen[ST_BAD_INDEX]);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sst_pkg.sv
hdl/sst_ctrl.sv
hdl/sst_dpath.sv
hdl/segment_summary_table.sv
hdl/sst_checker.sv
bench/tb_top.sv
